[sv/clfl_pkg.sv]
// Shared types, codes and the microcode table of the cursor list block.
package clfl_pkg;

	localparam int PTR_W     = 4;
	localparam int DEPTH_DEF = 8;
	localparam logic [PTR_W-1:0] NIL = 4'd15;

	localparam logic FUNC_INS = 1'b0;
	localparam logic FUNC_DEL = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOTIN = 2'd2
	} status_t;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
		logic [PTR_W-1:0]   slot;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PTR_W-1:0] slot_used;
	} rsp_t;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_INIT_INS,
		UOP_WALK,
		UOP_TAKE,
		UOP_LINK_TAIL,
		UOP_INIT_DEL,
		UOP_DWALK,
		UOP_UNLINK,
		UOP_PUSH,
		UOP_REPORT
	} uop_t;

	// Jump conditions: taken goes to target, otherwise to the next step
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_IS_DEL,
		C_FREE_EMPTY,
		C_WALKING,
		C_WALK_END,
		C_SLOT_BAD,
		C_SEARCHING
	} cond_t;

	typedef enum logic [3:0] {
		S_DISP   = 4'd0,
		S_IINIT  = 4'd1,
		S_IWALK  = 4'd2,
		S_ITAKE  = 4'd3,
		S_ILINK  = 4'd4,
		S_DINIT  = 4'd5,
		S_DWALK  = 4'd6,
		S_DTEST  = 4'd7,
		S_DUNL   = 4'd8,
		S_DPUSH  = 4'd9,
		S_FIN    = 4'd10
	} step_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} uword_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			S_DISP:  w = '{op: UOP_NOP,       cond: C_IS_DEL,     target: S_DINIT};
			S_IINIT: w = '{op: UOP_INIT_INS,  cond: C_FREE_EMPTY, target: S_FIN};
			S_IWALK: w = '{op: UOP_WALK,      cond: C_WALKING,    target: S_IWALK};
			S_ITAKE: w = '{op: UOP_TAKE,      cond: C_NEXT,       target: S_FIN};
			S_ILINK: w = '{op: UOP_LINK_TAIL, cond: C_ALWAYS,     target: S_FIN};
			S_DINIT: w = '{op: UOP_INIT_DEL,  cond: C_SLOT_BAD,   target: S_FIN};
			S_DWALK: w = '{op: UOP_DWALK,     cond: C_SEARCHING,  target: S_DWALK};
			S_DTEST: w = '{op: UOP_NOP,       cond: C_WALK_END,   target: S_FIN};
			S_DUNL:  w = '{op: UOP_UNLINK,    cond: C_NEXT,       target: S_FIN};
			S_DPUSH: w = '{op: UOP_PUSH,      cond: C_ALWAYS,     target: S_FIN};
			S_FIN:   w = '{op: UOP_REPORT,    cond: C_ALWAYS,     target: S_DISP};
			default: w = '{op: UOP_REPORT,    cond: C_ALWAYS,     target: S_DISP};
		endcase
		return w;
	endfunction

endpackage

[sv/cursor_list_with_free_list_top.sv]
// Cursor linked list with free list over a fixed node store, run by a microcode sequencer.
//
//  channel   ports                  handshake
//  --------  ---------------------  -------------------------------------------
//  command   start, cmd             taken at an edge with start high, busy low
//  result    done, rsp              done high for one cycle; cannot be stalled
//
//  An insert walks the list to its tail; a delete walks from the head until
//  it meets the slot, or to the end when the slot is not in the list. An insert
//  on a full store and a delete of a slot out of range end without a walk.
//  The walk reads one link per cycle from the link store.
//  The result strobe comes in the cycle after the last step; busy is already
//  low then. Reset restores the initial free chain at once; no clearing pass.
module cursor_list_with_free_list_top #(
	parameter int DEPTH = clfl_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  clfl_pkg::cmd_t cmd,
	output logic           done,
	output clfl_pkg::rsp_t rsp
);
	import clfl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic is_node(input logic [PTR_W-1:0] p);
		return p < PTR_W'(DEPTH);
	endfunction

	logic [PTR_W-1:0]   link_q [DEPTH];
	logic signed [31:0] value_mem [DEPTH];
	logic [PTR_W-1:0]   free_head_q, list_head_q;
	logic               busy_q, done_q;
	step_t              pc_q;

	cmd_t               cmd_q;
	rsp_t               rsp_q;
	logic [PTR_W-1:0]   cur_q, aux_q;
	logic [CW-1:0]      cnt_q;

	uword_t             uw;
	uop_t               op;
	logic               walk_end, hit;
	step_t              pc_next;
	logic [PTR_W-1:0]   rd_ptr, link_rd;

	always_comb begin
		uw       = ucode(pc_q);
		op       = busy_q ? uw.op : UOP_NOP;
		walk_end = (cnt_q == CW'(DEPTH)) || !is_node(cur_q);
		case (uw.cond)
			C_NEXT:       hit = 1'b0;
			C_ALWAYS:     hit = 1'b1;
			C_IS_DEL:     hit = (cmd_q.func == FUNC_DEL);
			C_FREE_EMPTY: hit = !is_node(free_head_q);
			C_WALKING:    hit = !walk_end;
			C_WALK_END:   hit = walk_end;
			C_SLOT_BAD:   hit = !is_node(cmd_q.slot);
			C_SEARCHING:  hit = !walk_end && (cur_q != cmd_q.slot);
			default:      hit = 1'b1;
		endcase
		pc_next = hit ? uw.target : step_t'(pc_q + 4'd1);

		case (op)
			UOP_TAKE:   rd_ptr = free_head_q;
			UOP_UNLINK: rd_ptr = cmd_q.slot;
			default:    rd_ptr = cur_q;
		endcase
		link_rd = is_node(rd_ptr) ? link_q[rd_ptr[IW-1:0]] : NIL;
	end

	// Sequencer, heads and link store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			pc_q        <= S_DISP;
			free_head_q <= '0;
			list_head_q <= NIL;
			for (int i = 0; i < DEPTH; i++) begin
				link_q[i] <= (i + 1 < DEPTH) ? PTR_W'(i + 1) : NIL;
			end
		end else begin
			done_q <= (op == UOP_REPORT);
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					pc_q   <= S_DISP;
				end
			end else begin
				pc_q <= pc_next;
				if (op == UOP_REPORT) begin
					busy_q <= 1'b0;
				end
			end
			case (op)
				UOP_TAKE: begin
					free_head_q <= link_rd;
					link_q[free_head_q[IW-1:0]] <= NIL;
				end
				UOP_LINK_TAIL: begin
					if (is_node(aux_q)) link_q[aux_q[IW-1:0]] <= rsp_q.slot_used;
					else list_head_q <= rsp_q.slot_used;
				end
				UOP_UNLINK: begin
					if (is_node(aux_q)) link_q[aux_q[IW-1:0]] <= link_rd;
					else list_head_q <= link_rd;
				end
				UOP_PUSH: begin
					link_q[cmd_q.slot[IW-1:0]] <= free_head_q;
					free_head_q <= cmd_q.slot;
				end
				default: ;
			endcase
		end
	end

	// Walk registers, command latch, result and value store
	always_ff @(posedge clk) begin
		if (start && !busy_q) cmd_q <= cmd;
		case (op)
			UOP_INIT_INS, UOP_INIT_DEL: begin
				cur_q  <= list_head_q;
				aux_q  <= NIL;
				cnt_q  <= '0;
				rsp_q.status    <= (op == UOP_INIT_INS) ? STAT_FULL : STAT_NOTIN;
				rsp_q.slot_used <= NIL;
			end
			UOP_WALK: begin
				if (!walk_end) begin
					aux_q <= cur_q;
					cur_q <= link_rd;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			UOP_DWALK: begin
				if (!walk_end && (cur_q != cmd_q.slot)) begin
					aux_q <= cur_q;
					cur_q <= link_rd;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			UOP_TAKE: begin
				value_mem[free_head_q[IW-1:0]] <= cmd_q.value;
				rsp_q.status    <= STAT_DONE;
				rsp_q.slot_used <= free_head_q;
			end
			UOP_PUSH: begin
				rsp_q.status    <= STAT_DONE;
				rsp_q.slot_used <= cmd_q.slot;
			end
			default: ;
		endcase
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without a transaction in flight");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

	a_heads_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(is_node(free_head_q) && is_node(list_head_q)) |-> (free_head_q != list_head_q))
		else $error("free list and list share a head node");

	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == STAT_DONE)) |-> is_node(rsp.slot_used))
		else $error("successful result names no node");
`endif

endmodule

[sim/tb_top.sv]
// Testbench for the cursor list block: directed table, random traffic, typed or predicted results.
`timescale 1ns / 100ps

module tb_top;
	import clfl_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct {
		cmd_t c;
		bit   has_ref;
		rsp_t r;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;

	// predictor state
	logic [31:0]      node_val [DEPTH];
	logic [PTR_W-1:0] node_nxt [DEPTH];
	logic [PTR_W-1:0] free_ptr;
	logic [PTR_W-1:0] head_ptr;

	rsp_t      pending_rsp [$];
	stim_row_t dir_tab [$];
	int        n_err;
	int        idle_pct;
	rsp_t      want;

	cursor_list_with_free_list_top #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void list_reset();
		for (int i = 0; i < DEPTH; i++) begin
			node_val[i] = '0;
			node_nxt[i] = (i + 1 < DEPTH) ? PTR_W'(i + 1) : NIL;
		end
		free_ptr = '0;
		head_ptr = NIL;
	endfunction

	// Apply one command to the list copy and return the response it produces.
	function automatic rsp_t list_apply(input cmd_t c);
		rsp_t             r;
		logic [PTR_W-1:0] fresh;
		logic [PTR_W-1:0] tail;
		logic [PTR_W-1:0] cur;
		logic [PTR_W-1:0] prev;
		bit               found;
		int               i;
		r.status = STAT_DONE;
		r.slot_used = NIL;
		if (c.func == FUNC_INS) begin
			fresh = free_ptr;
			if (fresh >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				tail = NIL;
				cur = head_ptr;
				for (i = 0; i < DEPTH && cur < DEPTH; i++) begin
					tail = cur;
					cur = node_nxt[cur];
				end
				free_ptr = node_nxt[fresh];
				node_val[fresh] = c.value;
				node_nxt[fresh] = NIL;
				if (tail < DEPTH)
					node_nxt[tail] = fresh;
				else
					head_ptr = fresh;
				r.slot_used = fresh;
			end
		end else begin
			prev = NIL;
			cur = head_ptr;
			found = 1'b0;
			if (c.slot < DEPTH) begin
				for (i = 0; i < DEPTH && cur < DEPTH; i++) begin
					if (cur == c.slot) begin
						found = 1'b1;
						break;
					end
					prev = cur;
					cur = node_nxt[cur];
				end
			end
			if (found) begin
				if (prev < DEPTH)
					node_nxt[prev] = node_nxt[c.slot];
				else
					head_ptr = node_nxt[c.slot];
				node_nxt[c.slot] = free_ptr;
				free_ptr = c.slot;
				r.slot_used = c.slot;
			end else begin
				r.status = STAT_NOTIN;
			end
		end
		return r;
	endfunction

	// Random slot currently linked in the list; any slot when the list is empty.
	function automatic logic [PTR_W-1:0] pick_listed();
		logic [PTR_W-1:0] cur;
		int               n;
		int               k;
		n = 0;
		cur = head_ptr;
		while (n < DEPTH && cur < DEPTH) begin
			n++;
			cur = node_nxt[cur];
		end
		if (n == 0)
			return PTR_W'($urandom_range(0, 15));
		k = $urandom_range(0, n - 1);
		cur = head_ptr;
		repeat (k) cur = node_nxt[cur];
		return cur;
	endfunction

	function automatic stim_row_t row(input logic f, input logic [31:0] v,
			input logic [PTR_W-1:0] s, input bit has_ref, input status_t st,
			input logic [PTR_W-1:0] used);
		stim_row_t t;
		t.c.func = f;
		t.c.value = v;
		t.c.slot = s;
		t.has_ref = has_ref;
		t.r.status = st;
		t.r.slot_used = used;
		return t;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Drive one transaction, wait for acceptance, queue its response, then idle for a random gap, if any.
	task automatic issue(input cmd_t c, input bit has_ref, input rsp_t ref_rsp);
		rsp_t pred;
		int   gap;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		pred = list_apply(c);
		pending_rsp.push_back(has_ref ? ref_rsp : pred);
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response checker
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected response: status=%0d slot_used=%0d",
						rsp.status, rsp.slot_used);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.slot_used !== want.slot_used) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: expected status=%0d slot_used=%0d, got status=%0d slot_used=%0d",
							want.status, want.slot_used, rsp.status, rsp.slot_used);
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		cmd_t c;
		rsp_t none;
		int   ins_pct;
		int   phase_idle [4];
		int   r;
		int   wait_cnt;
		n_err = 0;
		idle_pct = 0;
		none.status = STAT_DONE;
		none.slot_used = NIL;
		phase_idle = '{0, 79, 24, 0};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		list_reset();

		// empty list, bounds, fill, full, unlink head/middle/tail, refill
		dir_tab.push_back(row(FUNC_DEL, 32'h0000_0000, 4'd0,  TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'hffff_ffff, 4'd15, TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'h1234_5678, 4'd8,  TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_INS, 32'h8000_0000, 4'd15, TYPED, STAT_DONE, 4'd0));
		dir_tab.push_back(row(FUNC_INS, 32'h7fff_ffff, 4'd0,  TYPED, STAT_DONE, 4'd1));
		dir_tab.push_back(row(FUNC_INS, 32'h0000_0000, 4'd10, TYPED, STAT_DONE, 4'd2));
		dir_tab.push_back(row(FUNC_INS, 32'hffff_ffff, 4'd5,  TYPED, STAT_DONE, 4'd3));
		dir_tab.push_back(row(FUNC_INS, 32'h0000_0001, 4'd3,  TYPED, STAT_DONE, 4'd4));
		dir_tab.push_back(row(FUNC_INS, 32'hdead_beef, 4'd12, TYPED, STAT_DONE, 4'd5));
		dir_tab.push_back(row(FUNC_INS, 32'h5555_aaaa, 4'd6,  TYPED, STAT_DONE, 4'd6));
		dir_tab.push_back(row(FUNC_INS, 32'haaaa_5555, 4'd9,  TYPED, STAT_DONE, 4'd7));
		dir_tab.push_back(row(FUNC_INS, 32'h0bad_f00d, 4'd0,  TYPED, STAT_FULL, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'h0000_0000, 4'd3,  TYPED, STAT_DONE, 4'd3));
		dir_tab.push_back(row(FUNC_DEL, 32'hffff_ffff, 4'd0,  TYPED, STAT_DONE, 4'd0));
		dir_tab.push_back(row(FUNC_DEL, 32'h8000_0000, 4'd7,  TYPED, STAT_DONE, 4'd7));
		dir_tab.push_back(row(FUNC_DEL, 32'h7fff_ffff, 4'd3,  TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_INS, 32'h1111_1111, 4'd15, PREDICTED, STAT_DONE, NIL));
		dir_tab.push_back(row(FUNC_INS, 32'h2222_2222, 4'd1,  PREDICTED, STAT_DONE, NIL));
		dir_tab.push_back(row(FUNC_INS, 32'h3333_3333, 4'd7,  PREDICTED, STAT_DONE, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'hffff_ffff, 4'd15, TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_INS, 32'h4444_4444, 4'd2,  TYPED, STAT_FULL, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'h0000_0000, 4'd9,  TYPED, STAT_NOTIN, NIL));
		dir_tab.push_back(row(FUNC_DEL, 32'h0000_0000, 4'd4,  PREDICTED, STAT_DONE, NIL));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			issue(dir_tab[i].c, dir_tab[i].has_ref, dir_tab[i].r);

		ins_pct = 50;
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			for (int n = 0; n < 100; n++) begin
				// shift the insert/delete mix so the list swings between empty and full
				if (n % 20 == 0) begin
					case ($urandom_range(0, 2))
						0: ins_pct = 25;
						1: ins_pct = 50;
						default: ins_pct = 80;
					endcase
				end
				c.value = rand_word();
				c.slot = PTR_W'($urandom_range(0, 15));
				if ($urandom_range(0, 99) < ins_pct) begin
					c.func = FUNC_INS;
				end else begin
					c.func = FUNC_DEL;
					r = $urandom_range(0, 99);
					if (r < 75)
						c.slot = pick_listed();
					else if (r < 88)
						c.slot = (free_ptr < DEPTH) ? free_ptr : c.slot;
					else if (r < 94)
						c.slot = PTR_W'($urandom_range(DEPTH, 15));
				end
				issue(c, PREDICTED, none);
			end
		end
		start <= 1'b0;

		wait_cnt = 0;
		while (pending_rsp.size() != 0 && wait_cnt < 2000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (3 * DEPTH + 10) @(posedge clk);

		if (n_err == 0 && pending_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
sv/clfl_pkg.sv
sv/cursor_list_with_free_list_top.sv
sim/tb_top.sv
